// ===== rtl/core/rmsp_pkg.sv =====
`timescale 1ns / 1ps
package rmsp_pkg;

  // register and field widths
  localparam int REG_W = 17;
  localparam int GW    = 32;
  localparam int MSW   = 31;
  localparam int NW    = REG_W + GW;   // width of |learning_rate * grad|

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = FIFO_AW + 1;

  localparam logic [REG_W-1:0] DECAY_RST = 17'd58982;
  localparam logic [REG_W-1:0] MOM_RST   = 17'd0;
  localparam logic [REG_W-1:0] EPS_RST   = 17'd1;
  localparam logic [REG_W-1:0] LR_RST    = 17'd655;

  localparam logic [MSW-1:0] MS_MAX = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    REG_DECAY = 2'd0,
    REG_MOM   = 2'd1,
    REG_EPS   = 2'd2,
    REG_LR    = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [REG_W-1:0] decay;
    logic [REG_W-1:0] mom;
    logic [REG_W-1:0] eps;
    logic [REG_W-1:0] lr;
  } cfg_t;

  typedef struct packed {
    logic [GW-1:0]        g_mag;
    logic                 g_neg;
    logic [MSW-1:0]       ms;
    logic signed [GW-1:0] mom;
    logic                 last;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== rtl/core/rmsp_front.sv =====
`timescale 1ns / 1ps
module rmsp_front (
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [31:0]    grad_in_i,
  input  logic [30:0]           mean_sq_in_i,
  input  logic signed [31:0]    momentum_in_i,
  input  logic                  last_in_i,
  input  rmsp_pkg::fifo_stat_t  fifo_stat_i,
  output logic                  push_o,
  output rmsp_pkg::item_t       item_o
);
  import rmsp_pkg::*;

  logic neg;

  // split the gradient into sign and magnitude for the unsigned multipliers
  assign neg            = grad_in_i[GW-1];
  assign item_o.g_neg   = neg;
  assign item_o.g_mag   = neg ? (~grad_in_i + 32'd1) : grad_in_i;
  assign item_o.ms      = mean_sq_in_i;
  assign item_o.mom     = momentum_in_i;
  assign item_o.last    = last_in_i;

  assign in_stall_o = fifo_stat_i.full;
  assign push_o     = in_valid_i && !fifo_stat_i.full;

endmodule

// ===== rtl/core/rmsp_fifo.sv =====
`timescale 1ns / 1ps
module rmsp_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  rmsp_pkg::item_t       item_i,
  input  logic                  pop_i,
  output rmsp_pkg::item_t       item_o,
  output rmsp_pkg::fifo_stat_t  stat_o
);
  import rmsp_pkg::*;

  item_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CW-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign item_o       = mem[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + FIFO_CW'(push_i) - FIFO_CW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/rmsp_sqrt.sv =====
`timescale 1ns / 1ps
module rmsp_sqrt #(
  parameter int R  = 24,
  parameter int SW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*R-1:0]  arg_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [R-1:0]    root_o,
  output logic [SW-1:0]   side_o
);
  localparam int AW = 2 * R;
  localparam int RW = R + 3;

  logic [RW-1:0] rem_q  [R];
  logic [R-1:0]  root_q [R];
  logic [AW-1:0] x_q    [R];
  logic [SW-1:0] side_q [R];
  logic          vld_q  [R];

  // one result bit per stage, two radicand bits consumed per stage
  for (genvar j = 0; j < R; j++) begin : g_stage
    logic [RW-1:0] rem_p, shifted, trial;
    logic [R-1:0]  root_p;
    logic [AW-1:0] x_p;
    logic [SW-1:0] side_p;
    logic          vld_p;
    logic [RW-1:0] rem_n;
    logic [R-1:0]  root_n;

    if (j == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign x_p    = arg_i;
      assign side_p = side_i;
      assign vld_p  = valid_i;
    end else begin : g_next
      assign rem_p  = rem_q[j-1];
      assign root_p = root_q[j-1];
      assign x_p    = x_q[j-1];
      assign side_p = side_q[j-1];
      assign vld_p  = vld_q[j-1];
    end

    always_comb begin
      shifted = {rem_p[RW-3:0], x_p[AW-1:AW-2]};
      trial   = {1'b0, root_p, 2'b01};
      if (shifted >= trial) begin
        rem_n  = shifted - trial;
        root_n = {root_p[R-2:0], 1'b1};
      end else begin
        rem_n  = shifted;
        root_n = {root_p[R-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_n;
        root_q[j] <= root_n;
        x_q[j]    <= {x_p[AW-3:0], 2'b00};
        side_q[j] <= side_p;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_p;
      end
    end
  end

  assign valid_o = vld_q[R-1];
  assign root_o  = root_q[R-1];
  assign side_o  = side_q[R-1];

endmodule

// ===== rtl/core/rmsp_div.sv =====
`timescale 1ns / 1ps
module rmsp_div #(
  parameter int NB = 49,
  parameter int DB = 24,
  parameter int SW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NB-1:0]   num_i,
  input  logic [DB-1:0]   den_i,
  input  logic [SW-1:0]   side_i,
  output logic            valid_o,
  output logic [NB-1:0]   quo_o,
  output logic [SW-1:0]   side_o
);
  logic [DB-1:0] rem_q  [NB];
  logic [NB-1:0] dvd_q  [NB];
  logic [NB-1:0] quo_q  [NB];
  logic [DB-1:0] den_q  [NB];
  logic [SW-1:0] side_q [NB];
  logic          vld_q  [NB];

  // restoring division, one quotient bit per stage from the top
  for (genvar j = 0; j < NB; j++) begin : g_stage
    logic [DB-1:0] rem_p, den_p, rem_n;
    logic [NB-1:0] dvd_p, quo_p;
    logic [SW-1:0] side_p;
    logic          vld_p;
    logic [DB:0]   trial;
    logic          take;

    if (j == 0) begin : g_first
      assign rem_p  = '0;
      assign dvd_p  = num_i;
      assign quo_p  = '0;
      assign den_p  = den_i;
      assign side_p = side_i;
      assign vld_p  = valid_i;
    end else begin : g_next
      assign rem_p  = rem_q[j-1];
      assign dvd_p  = dvd_q[j-1];
      assign quo_p  = quo_q[j-1];
      assign den_p  = den_q[j-1];
      assign side_p = side_q[j-1];
      assign vld_p  = vld_q[j-1];
    end

    always_comb begin
      trial = {rem_p, dvd_p[NB-1]};
      take  = (trial >= {1'b0, den_p});
      rem_n = take ? DB'(trial - {1'b0, den_p}) : DB'(trial);
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= rem_n;
        dvd_q[j]  <= {dvd_p[NB-2:0], 1'b0};
        quo_q[j]  <= {quo_p[NB-2:0], take};
        den_q[j]  <= den_p;
        side_q[j] <= side_p;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_p;
      end
    end
  end

  assign valid_o = vld_q[NB-1];
  assign quo_o   = quo_q[NB-1];
  assign side_o  = side_q[NB-1];

endmodule

// ===== rtl/core/rmsp_back.sv =====
`timescale 1ns / 1ps
module rmsp_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rmsp_pkg::cfg_t        cfg_i,
  input  rmsp_pkg::item_t       item_i,
  input  rmsp_pkg::fifo_stat_t  fifo_stat_i,
  output logic                  pop_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [30:0]           mean_sq_out_o,
  output logic signed [31:0]    momentum_out_o,
  output logic                  saturated_o,
  output logic                  last_out_o
);
  import rmsp_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int SQW  = 2 * GW - F;
  localparam int DIFW = SQW + 1;
  localparam int D1W  = F + 1;
  localparam int HIW  = DIFW - 32;
  localparam int PLW  = 32 + D1W;
  localparam int PHW  = HIW + D1W + 1;
  localparam int PW   = DIFW + D1W + 1;
  localparam int NRW  = PW - F + 1;
  localparam int MPW  = GW + REG_W + 1;
  localparam int MW   = MPW - F;
  localparam int R    = (GW + F + 1) / 2;
  localparam int AW   = 2 * R;
  localparam int CW   = (REG_W > D1W) ? REG_W : D1W;
  localparam int OW   = ((MW > NW) ? MW : NW) + 2;
  localparam int DSW  = MSW + MW + 5;
  localparam int SSW  = NW + DSW;

  logic adv;

  // decay clamp to one and its complement
  logic [CW-1:0]  dec_ext, one_c, dec_c;
  logic [D1W-1:0] d1;

  always_comb begin
    dec_ext = CW'(cfg_i.decay);
    one_c   = CW'(1) << F;
    dec_c   = (dec_ext > one_c) ? one_c : dec_ext;
    d1      = D1W'(one_c - dec_c);
  end

  assign adv   = !(out_valid_o && out_stall_i);
  assign pop_o = adv && !fifo_stat_i.empty;

  // stage 1: square of the gradient
  logic                 s1_v_q;
  logic [SQW-1:0]       s1_sq_q;
  logic [GW-1:0]        s1_gm_q;
  logic                 s1_neg_q, s1_last_q;
  logic [MSW-1:0]       s1_ms_q;
  logic signed [GW-1:0] s1_mom_q;
  logic [2*GW-1:0]      sq_full;

  assign sq_full = {{GW{1'b0}}, item_i.g_mag} * {{GW{1'b0}}, item_i.g_mag};

  // stage 2: difference to the old mean square, momentum product
  logic                  s2_v_q;
  logic signed [DIFW-1:0] s2_diff_q;
  logic signed [MPW-1:0] s2_mp_q;
  logic [GW-1:0]         s2_gm_q;
  logic                  s2_neg_q, s2_last_q;
  logic [MSW-1:0]        s2_ms_q;
  logic signed [MPW-1:0] mp_c;

  assign mp_c = MPW'(s1_mom_q) * MPW'($signed({1'b0, cfg_i.mom}));

  // stage 3: decay partial products, numerator
  logic                  s3_v_q;
  logic [PLW-1:0]        s3_plo_q;
  logic signed [PHW-1:0] s3_phi_q;
  logic [NW-1:0]         s3_num_q;
  logic signed [MPW-1:0] s3_mp_q;
  logic                  s3_neg_q, s3_last_q;
  logic [MSW-1:0]        s3_ms_q;
  logic signed [HIW-1:0] diff_hi;

  assign diff_hi = s2_diff_q[DIFW-1:32];

  // stage 4: combine the partial products
  logic                  s4_v_q;
  logic signed [PW-1:0]  s4_prod_q;
  logic [NW-1:0]         s4_num_q;
  logic signed [MPW-1:0] s4_mp_q;
  logic                  s4_neg_q, s4_last_q;
  logic [MSW-1:0]        s4_ms_q;

  // stage 5: new mean square with clamp, radicand
  logic                  s5_v_q;
  logic [AW-1:0]         s5_arg_q;
  logic [NW-1:0]         s5_num_q;
  logic [MSW-1:0]        s5_nms_q;
  logic signed [MW-1:0]  s5_m_q;
  logic                  s5_neg_q, s5_sat_q, s5_last_q, s5_dz_q, s5_nz_q;

  logic signed [NRW-1:0] nms_raw;
  logic [MSW-1:0]        nms_c;
  logic                  sat_c;
  logic [31:0]           rad_sum;

  always_comb begin
    nms_raw = $signed(NRW'(s4_ms_q)) + NRW'(s4_prod_q >>> F);
    if (nms_raw < 0) begin
      nms_c = '0;
      sat_c = 1'b1;
    end else if (nms_raw > $signed(NRW'(MS_MAX))) begin
      nms_c = MS_MAX;
      sat_c = 1'b1;
    end else begin
      nms_c = MSW'(nms_raw);
      sat_c = 1'b0;
    end
    rad_sum = 32'(cfg_i.eps) + 32'(nms_c);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_sq_q   <= sq_full[2*GW-1:F];
      s1_gm_q   <= item_i.g_mag;
      s1_neg_q  <= item_i.g_neg;
      s1_ms_q   <= item_i.ms;
      s1_mom_q  <= item_i.mom;
      s1_last_q <= item_i.last;

      s2_diff_q <= $signed({1'b0, s1_sq_q}) - $signed(DIFW'(s1_ms_q));
      s2_mp_q   <= mp_c;
      s2_gm_q   <= s1_gm_q;
      s2_neg_q  <= s1_neg_q;
      s2_ms_q   <= s1_ms_q;
      s2_last_q <= s1_last_q;

      s3_plo_q  <= PLW'(s2_diff_q[31:0]) * PLW'(d1);
      s3_phi_q  <= PHW'(diff_hi) * PHW'($signed({1'b0, d1}));
      s3_num_q  <= NW'(cfg_i.lr) * NW'(s2_gm_q);
      s3_mp_q   <= s2_mp_q;
      s3_neg_q  <= s2_neg_q;
      s3_ms_q   <= s2_ms_q;
      s3_last_q <= s2_last_q;

      s4_prod_q <= (PW'(s3_phi_q) <<< 32) + $signed(PW'(s3_plo_q));
      s4_num_q  <= s3_num_q;
      s4_mp_q   <= s3_mp_q;
      s4_neg_q  <= s3_neg_q;
      s4_ms_q   <= s3_ms_q;
      s4_last_q <= s3_last_q;

      s5_arg_q  <= AW'(rad_sum) << F;
      s5_num_q  <= s4_num_q;
      s5_nms_q  <= nms_c;
      s5_m_q    <= MW'(s4_mp_q >>> F);
      s5_neg_q  <= s4_neg_q;
      s5_sat_q  <= sat_c;
      s5_last_q <= s4_last_q;
      s5_dz_q   <= (rad_sum == '0);
      s5_nz_q   <= (s4_num_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
    end else if (adv) begin
      s1_v_q <= !fifo_stat_i.empty;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
    end
  end

  // square root, then divider
  logic           sq_v;
  logic [R-1:0]   den;
  logic [SSW-1:0] sq_side;
  logic           dv_v;
  logic [NW-1:0]  quo;
  logic [DSW-1:0] dv_side;

  rmsp_sqrt #(
    .R  (R),
    .SW (SSW)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s5_v_q),
    .arg_i   (s5_arg_q),
    .side_i  ({s5_num_q, s5_nms_q, s5_m_q, s5_neg_q, s5_sat_q, s5_last_q, s5_dz_q,
               s5_nz_q}),
    .valid_o (sq_v),
    .root_o  (den),
    .side_o  (sq_side)
  );

  rmsp_div #(
    .NB (NW),
    .DB (R),
    .SW (DSW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (sq_v),
    .num_i   (sq_side[SSW-1:DSW]),
    .den_i   (den),
    .side_i  (sq_side[DSW-1:0]),
    .valid_o (dv_v),
    .quo_o   (quo),
    .side_o  (dv_side)
  );

  // final stage: sign the quotient, add the momentum term, clamp
  logic [MSW-1:0]       f_nms;
  logic signed [MW-1:0] f_m;
  logic                 f_neg, f_sat, f_last, f_dz, f_nz;
  logic signed [OW-1:0] q_s, nmom;
  logic signed [GW-1:0] mom_c;
  logic                 sat_o_c;

  assign {f_nms, f_m, f_neg, f_sat, f_last, f_dz, f_nz} = dv_side;

  always_comb begin
    sat_o_c = f_sat;
    if (f_dz) begin
      sat_o_c = 1'b1;
      if (f_nz) begin
        q_s = '0;
      end else if (f_neg) begin
        q_s = -$signed(OW'(33'h1_0000_0000) >>> 1);
      end else begin
        q_s = $signed(OW'(32'h7FFF_FFFF));
      end
    end else begin
      q_s = f_neg ? -$signed(OW'(quo)) : $signed(OW'(quo));
    end
    nmom = OW'(f_m) + q_s;
    if (nmom > $signed(OW'(32'h7FFF_FFFF))) begin
      mom_c   = 32'sh7FFF_FFFF;
      sat_o_c = 1'b1;
    end else if (nmom < -$signed(OW'(33'h1_0000_0000) >>> 1)) begin
      mom_c   = 32'sh8000_0000;
      sat_o_c = 1'b1;
    end else begin
      mom_c   = GW'(nmom);
    end
  end

  logic                 out_v_q;
  logic [MSW-1:0]       out_ms_q;
  logic signed [GW-1:0] out_mom_q;
  logic                 out_sat_q, out_last_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_ms_q   <= f_nms;
      out_mom_q  <= mom_c;
      out_sat_q  <= sat_o_c;
      out_last_q <= f_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= dv_v;
    end
  end

  assign out_valid_o    = out_v_q;
  assign mean_sq_out_o  = out_ms_q;
  assign momentum_out_o = out_mom_q;
  assign saturated_o    = out_sat_q;
  assign last_out_o     = out_last_q;

endmodule

// ===== rtl/core/rmsprop_param_update.sv =====
`timescale 1ns / 1ps
// RMSProp update for one parameter element per transaction, signed fixed point with
// FRAC_BITS fraction bits. Each input transaction (gradient, old mean square, old
// momentum, last mark) yields exactly one output transaction, in order. One element
// is taken every clock cycle while the output side keeps up; the path from input
// acceptance to output valid runs through the mean square stages, the bit-per-stage
// square root, the 49-stage restoring divider and the output register.
// A four-entry queue behind the input lets up to four transactions land while the
// output is stalled; the whole back pipeline holds on an output stall.
// Registers sit on the APB port at 0x0 decay, 0x4 momentum factor, 0x8 epsilon and
// 0xC learning rate, 17 bits each; write them only while the block is empty.
module rmsprop_param_update #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] grad_in_i,
  input  logic [30:0]        mean_sq_in_i,
  input  logic signed [31:0] momentum_in_i,
  input  logic               last_in_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [30:0]        mean_sq_out_o,
  output logic signed [31:0] momentum_out_o,
  output logic               saturated_o,
  output logic               last_out_o
);
  import rmsp_pkg::*;

  cfg_t       cfg_q, cfg_d;
  reg_idx_e   idx;
  logic       wr_en;
  logic       push, pop;
  item_t      item_w, item_r;
  fifo_stat_t fifo_stat;

  // register file: write on the access phase, read back combinationally
  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_DECAY: cfg_d.decay = pwdata[REG_W-1:0];
        REG_MOM:   cfg_d.mom   = pwdata[REG_W-1:0];
        REG_EPS:   cfg_d.eps   = pwdata[REG_W-1:0];
        REG_LR:    cfg_d.lr    = pwdata[REG_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DECAY: prdata = 32'(cfg_q.decay);
      REG_MOM:   prdata = 32'(cfg_q.mom);
      REG_EPS:   prdata = 32'(cfg_q.eps);
      REG_LR:    prdata = 32'(cfg_q.lr);
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.decay <= DECAY_RST;
      cfg_q.mom   <= MOM_RST;
      cfg_q.eps   <= EPS_RST;
      cfg_q.lr    <= LR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front: take the transaction and split sign from magnitude
  rmsp_front u_front (
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .grad_in_i     (grad_in_i),
    .mean_sq_in_i  (mean_sq_in_i),
    .momentum_in_i (momentum_in_i),
    .last_in_i     (last_in_i),
    .fifo_stat_i   (fifo_stat),
    .push_o        (push),
    .item_o        (item_w)
  );

  // queue: decouple the input handshake from the pipeline stall
  rmsp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .item_i (item_w),
    .pop_i  (pop),
    .item_o (item_r),
    .stat_o (fifo_stat)
  );

  // back: mean square, square root, divide, momentum, output register
  rmsp_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .item_i         (item_r),
    .fifo_stat_i    (fifo_stat),
    .pop_o          (pop),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .mean_sq_out_o  (mean_sq_out_o),
    .momentum_out_o (momentum_out_o),
    .saturated_o    (saturated_o),
    .last_out_o     (last_out_o)
  );

`ifndef SYNTH
  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && idx == REG_DECAY) |=> (cfg_q.decay == $past(pwdata[REG_W-1:0])))
    else $error("decay register write lost");

  a_fifo_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(fifo_stat.full && fifo_stat.empty))
    else $error("queue full and empty at once");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !fifo_stat.empty)
    else $error("accepted transaction missing from queue");
`endif

endmodule
